@@ hdl/pms_pkg.sv @@
// Shared types, register indexes and exp table builders for the particle motion step.
package pms_pkg;

    typedef struct packed {
        logic [31:0]        time_now;
        logic [15:0]        time_step;
        logic [31:0]        start_delay;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] vel_x_in;
        logic signed [31:0] vel_y_in;
        logic signed [31:0] angle_in;
        logic signed [31:0] spin_rate;
        logic [16:0]        alpha_in;
        logic               alive_in;
    } t_item;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] angle_out;
        logic [16:0]        alpha_out;
        logic               alive_out;
    } t_result;

    localparam logic [2:0] CFG_GRAVITY     = 3'd0;
    localparam logic [2:0] CFG_DRAG        = 3'd1;
    localparam logic [2:0] CFG_FADE        = 3'd2;
    localparam logic [2:0] CFG_SCREEN_W    = 3'd3;
    localparam logic [2:0] CFG_SCREEN_H    = 3'd4;
    localparam logic [2:0] CFG_CELL_HALF_W = 3'd5;
    localparam logic [2:0] CFG_CELL_HALF_H = 3'd6;

    localparam int MAX_WHOLE_EXP = 16;

    // exp(-k/2^bits) in Q1.32 from a Taylor series truncated after the 24th power
    function automatic logic [32:0] exp_entry(input int k, input int bits);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'd1 << 32;
        sum  = $signed(term);
        for (int i = 1; i <= 24; i++) begin
            term = ((term * 64'(k)) >> bits) / 64'(i);
            if (i % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
        end
        if (sum < 0) return 33'd0;
        return sum[32:0];
    endfunction

    // exp(-1)^n for n >= 1 (n = 0 also gives exp(-1)), rounded at each multiply, clamped below one
    function automatic logic [31:0] pow_entry(input int n, input int bits);
        logic [63:0] r;
        logic [63:0] en;
        r  = 64'(exp_entry(1 << bits, bits));
        en = r;
        for (int i = 1; i < n; i++) begin
            en = (en * r + 64'h8000_0000) >> 32;
        end
        if (en >= (64'd1 << 32)) en = (64'd1 << 32) - 64'd1;
        return en[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648) return 32'sh8000_0000;
        else                           return v[31:0];
    endfunction

endpackage

@@ hdl/particle_motion_step.sv @@
// Particle motion step: one Euler update of a particle per clock, with drag and fade.
// One item per cycle, busy never rises.
// Depth set by the exp lookup and power chain (4 stages) plus velocity, position, bounds.
// Reset (synchronous, active low) clears valid bits and loads register defaults.
// The result shows for one cycle; the receiver cannot stall.
module particle_motion_step #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pms_pkg::t_item  i_item,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    output logic            o_strobe,
    output pms_pkg::t_result o_result
);
    import pms_pkg::*;

    typedef struct packed {
        logic               go;
        logic [15:0]        dt;
        logic signed [31:0] px, py, vx, vy, ang, gdt, sdt;
        logic [16:0]        alpha;
        logic               alive;
    } t_s1;

    typedef struct packed {
        logic               go;
        logic [15:0]        dt;
        logic signed [31:0] px, py, vx, vy, vy_g, ang, ang_n;
        logic [16:0]        alpha;
        logic               alive;
    } t_mid;

    typedef struct packed {
        logic               go;
        logic [15:0]        dt;
        logic signed [31:0] px, py, vx, vy, vx_d, vy_d, ang, ang_n;
        logic [16:0]        alpha, alpha_n;
        logic               alive;
    } t_vel;

    logic signed [31:0] r_gravity;
    logic [23:0]        r_drag, r_fade;
    logic [12:0]        r_screen_w, r_screen_h;
    logic [9:0]         r_chw, r_chh;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= '0;
            r_drag     <= '0;
            r_fade     <= 24'd65536;
            r_screen_w <= 13'd1920;
            r_screen_h <= 13'd1080;
            r_chw      <= 10'd16;
            r_chh      <= 10'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAVITY:     r_gravity  <= i_cfg_data;
                CFG_DRAG:        r_drag     <= i_cfg_data[23:0];
                CFG_FADE:        r_fade     <= i_cfg_data[23:0];
                CFG_SCREEN_W:    r_screen_w <= i_cfg_data[12:0];
                CFG_SCREEN_H:    r_screen_h <= i_cfg_data[12:0];
                CFG_CELL_HALF_W: r_chw      <= i_cfg_data[9:0];
                CFG_CELL_HALF_H: r_chh      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // stage 1: products with the time step, elapsed time
    logic signed [48:0] w_gmul, w_smul;
    logic [39:0]        w_xmul;
    t_s1                n_s1, r_s1;
    logic [23:0]        r_x;
    logic [31:0]        r_tau;
    logic [6:0]         r_v;

    assign w_gmul = r_gravity * $signed({1'b0, i_item.time_step});
    assign w_smul = i_item.spin_rate * $signed({1'b0, i_item.time_step});
    assign w_xmul = r_drag * i_item.time_step;

    always_comb begin
        n_s1.go    = (i_item.time_now >= i_item.start_delay);
        n_s1.dt    = i_item.time_step;
        n_s1.px    = i_item.pos_x_in;
        n_s1.py    = i_item.pos_y_in;
        n_s1.vx    = i_item.vel_x_in;
        n_s1.vy    = i_item.vel_y_in;
        n_s1.ang   = i_item.angle_in;
        n_s1.gdt   = w_gmul[47:16];
        n_s1.sdt   = w_smul[47:16];
        n_s1.alpha = i_item.alpha_in;
        n_s1.alive = i_item.alive_in;
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_x   <= w_xmul[39:16];
        r_tau <= i_item.time_now - i_item.start_delay;
    end

    // valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[5:0], start & ~busy};
    end

    logic [16:0] w_df, w_alpha_n;

    pms_drag #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_drag (
        .i_clk (i_clk),
        .i_x   (r_x),
        .o_df  (w_df)
    );

    pms_fade u_fade (
        .i_clk       (i_clk),
        .i_tau       (r_tau),
        .i_fade_rate (r_fade),
        .o_alpha     (w_alpha_n)
    );

    // stage 2: gravity, angle; stages 3..5 wait on drag and fade
    t_mid r_m [4];
    t_mid n_m;

    always_comb begin
        n_m.go    = r_s1.go;
        n_m.dt    = r_s1.dt;
        n_m.px    = r_s1.px;
        n_m.py    = r_s1.py;
        n_m.vx    = r_s1.vx;
        n_m.vy    = r_s1.vy;
        n_m.vy_g  = sat32(34'(r_s1.vy) + 34'(r_s1.gdt));
        n_m.ang   = r_s1.ang;
        n_m.ang_n = r_s1.ang + r_s1.sdt;
        n_m.alpha = r_s1.alpha;
        n_m.alive = r_s1.alive;
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= n_m;
        r_m[1] <= r_m[0];
        r_m[2] <= r_m[1];
        r_m[3] <= r_m[2];
    end

    // stage 6: drag on both velocities
    logic signed [49:0] w_vxm, w_vym;
    t_vel r_vl;

    assign w_vxm = r_m[3].vx * $signed({1'b0, w_df});
    assign w_vym = r_m[3].vy_g * $signed({1'b0, w_df});

    always_ff @(posedge i_clk) begin
        r_vl.go      <= r_m[3].go;
        r_vl.dt      <= r_m[3].dt;
        r_vl.px      <= r_m[3].px;
        r_vl.py      <= r_m[3].py;
        r_vl.vx      <= r_m[3].vx;
        r_vl.vy      <= r_m[3].vy;
        r_vl.vx_d    <= sat32(w_vxm[49:16]);
        r_vl.vy_d    <= sat32(w_vym[49:16]);
        r_vl.ang     <= r_m[3].ang;
        r_vl.ang_n   <= r_m[3].ang_n;
        r_vl.alpha   <= r_m[3].alpha;
        r_vl.alpha_n <= w_alpha_n;
        r_vl.alive   <= r_m[3].alive;
    end

    // stage 7: position
    logic signed [48:0] w_pxm, w_pym;
    t_vel               r_ps;
    logic signed [31:0] r_px_n, r_py_n;

    assign w_pxm = r_vl.vx_d * $signed({1'b0, r_vl.dt});
    assign w_pym = r_vl.vy_d * $signed({1'b0, r_vl.dt});

    always_ff @(posedge i_clk) begin
        r_ps   <= r_vl;
        r_px_n <= sat32(34'(r_vl.px) + 34'($signed(w_pxm[48:16])));
        r_py_n <= sat32(34'(r_vl.py) + 34'($signed(w_pym[48:16])));
    end

    // stage 8: bounds test and output register
    logic signed [33:0] w_xl, w_xh, w_yl, w_yh;
    logic [13:0]        w_wsum, w_hsum;
    logic               w_alive;

    always_comb begin
        w_wsum  = 14'(r_screen_w) + 14'({r_chw, 1'b0});
        w_hsum  = 14'(r_screen_h) + 14'({r_chh, 1'b0});
        w_xl    = -$signed(34'({r_chw, 17'd0}));
        w_yl    = -$signed(34'({r_chh, 17'd0}));
        w_xh    = $signed(34'({w_wsum, 16'd0}));
        w_yh    = $signed(34'({w_hsum, 16'd0}));
        w_alive = (r_ps.alpha_n != 17'd0)
                && (34'(r_px_n) > w_xl) && (34'(r_px_n) < w_xh)
                && (34'(r_py_n) > w_yl) && (34'(r_py_n) < w_yh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else          o_strobe <= r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (r_ps.go) begin
            o_result.pos_x_out <= r_px_n;
            o_result.pos_y_out <= r_py_n;
            o_result.vel_x_out <= r_ps.vx_d;
            o_result.vel_y_out <= r_ps.vy_d;
            o_result.angle_out <= r_ps.ang_n;
            o_result.alpha_out <= r_ps.alpha_n;
            o_result.alive_out <= w_alive;
        end else begin
            o_result.pos_x_out <= r_ps.px;
            o_result.pos_y_out <= r_ps.py;
            o_result.vel_x_out <= r_ps.vx;
            o_result.vel_y_out <= r_ps.vy;
            o_result.angle_out <= r_ps.ang;
            o_result.alpha_out <= r_ps.alpha;
            o_result.alive_out <= r_ps.alive;
        end
    end

endmodule

@@ hdl/pms_drag.sv @@
// Four stage drag factor unit: exp(-x) for x in Q8.16, result Q1.16.
module pms_drag #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic [23:0] i_x,
    output logic [16:0] o_df
);
    import pms_pkg::*;

    localparam int ENTRIES   = (1 << EXP_TABLE_BITS) + 1;
    localparam int FRAC_BITS = 16 - EXP_TABLE_BITS;

    logic [32:0] w_rom [ENTRIES];
    logic [31:0] w_pow [MAX_WHOLE_EXP + 1];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
        assign w_rom[k] = exp_entry(k, EXP_TABLE_BITS);
    end
    for (genvar k = 0; k <= MAX_WHOLE_EXP; k++) begin : g_pow
        assign w_pow[k] = pow_entry(k, EXP_TABLE_BITS);
    end

    logic [7:0]                  w_n;
    logic [EXP_TABLE_BITS:0]     w_idx;
    logic [32:0]                 r_a, r_b;
    logic [FRAC_BITS-1:0]        r_fr;
    logic [31:0]                 r_en1, r_en2;
    logic                        r_nz1, r_nz2;
    logic                        r_big1, r_big2, r_big3;
    logic [32:0]                 r_val, r_e;
    logic [32:0]                 n_val, n_e;
    logic [33+FRAC_BITS-1:0]     w_dprod;
    logic [32:0]                 w_diff;
    logic [65:0]                 w_eprod;
    logic [17:0]                 w_rnd;

    assign w_n   = i_x[23:16];
    assign w_idx = {1'b0, i_x[15:FRAC_BITS]};

    always_ff @(posedge i_clk) begin
        r_a    <= w_rom[w_idx];
        r_b    <= w_rom[w_idx + 1'b1];
        r_fr   <= i_x[FRAC_BITS-1:0];
        r_en1  <= w_pow[w_n[4:0]];
        r_nz1  <= (w_n == 8'd0);
        r_big1 <= (w_n > 8'(MAX_WHOLE_EXP));
    end

    // linear interpolation between neighboring entries, step floored
    always_comb begin
        w_diff  = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
        w_dprod = w_diff * r_fr;
        if (r_a >= r_b) n_val = r_a - w_dprod[33+FRAC_BITS-1:FRAC_BITS];
        else            n_val = r_a + w_dprod[33+FRAC_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_en2  <= r_en1;
        r_nz2  <= r_nz1;
        r_big2 <= r_big1;
    end

    always_comb begin
        w_eprod = 66'(r_en2) * 66'(r_val) + 66'h8000_0000;
        n_e     = r_nz2 ? r_val : w_eprod[64:32];
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_big3 <= r_big2;
    end

    assign w_rnd = 18'((34'(r_e) + 34'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (r_big3)                 o_df <= 17'd0;
        else if (w_rnd > 18'd65536) o_df <= 17'd65536;
        else                        o_df <= w_rnd[16:0];
    end

endmodule

@@ hdl/pms_fade.sv @@
// Four stage fade unit: alpha = 1 - smoothstep(min(1, tau*fade_rate)).
module pms_fade (
    input  logic        i_clk,
    input  logic [31:0] i_tau,
    input  logic [23:0] i_fade_rate,
    output logic [16:0] o_alpha
);
    import pms_pkg::*;

    logic [55:0] w_p;
    logic [16:0] r_u;
    logic [33:0] r_uu;
    logic [17:0] r_m;
    logic [51:0] w_s;
    logic [16:0] r_alpha;

    assign w_p = i_tau * i_fade_rate;

    always_ff @(posedge i_clk) begin
        if (w_p[55:16] > 40'd65536) r_u <= 17'd65536;
        else                        r_u <= w_p[32:16];
        r_uu <= r_u * r_u;
        r_m  <= 18'd196608 - {r_u, 1'b0};
    end

    assign w_s = r_uu * r_m;

    always_ff @(posedge i_clk) begin
        r_alpha <= 17'd65536 - w_s[48:32];
        o_alpha <= r_alpha;
    end

endmodule
